/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/rc2cbc_pkg.sv */
// types, constants and helper functions of the rc2 cbc block
`default_nettype none
package rc2cbc_pkg;

	localparam logic [2:0] REG_KEY_LOW  = 3'd0;
	localparam logic [2:0] REG_KEY_HIGH = 3'd1;
	localparam logic [2:0] REG_KEY_LEN  = 3'd2;
	localparam logic [2:0] REG_EFF_BITS = 3'd3;
	localparam logic [2:0] REG_IV       = 3'd4;
	localparam logic [2:0] REG_MODE     = 3'd5;

	localparam logic [1:0] MODE_CBC     = 2'd0;
	localparam logic [1:0] MODE_DEC     = 2'd2;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_KEY  = 4'd1;
	localparam logic [3:0] OP_FILL = 4'd2;
	localparam logic [3:0] OP_RED  = 4'd3;
	localparam logic [3:0] OP_BACK = 4'd4;
	localparam logic [3:0] OP_LO   = 4'd5;
	localparam logic [3:0] OP_SK   = 4'd6;
	localparam logic [3:0] OP_MIX  = 4'd7;
	localparam logic [3:0] OP_MASH = 4'd8;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] w;
		logic [6:0] e_waddr;
		logic [6:0] e_raddr;
		logic [5:0] k_raddr;
		logic       k_rsel_data;
		logic [5:0] k_waddr;
		logic       in_load;
		logic       x_load;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [4:0] len;
		logic [7:0] t8;
		logic       key_wr;
		logic       dec;
	} status_t;

	localparam logic [7:0] PITABLE [256] = '{
		8'hd9, 8'h78, 8'hf9, 8'hc4, 8'h19, 8'hdd, 8'hb5, 8'hed, 8'h28, 8'he9, 8'hfd, 8'h79,
		8'h4a, 8'ha0, 8'hd8, 8'h9d, 8'hc6, 8'h7e, 8'h37, 8'h83, 8'h2b, 8'h76, 8'h53, 8'h8e,
		8'h62, 8'h4c, 8'h64, 8'h88, 8'h44, 8'h8b, 8'hfb, 8'ha2, 8'h17, 8'h9a, 8'h59, 8'hf5,
		8'h87, 8'hb3, 8'h4f, 8'h13, 8'h61, 8'h45, 8'h6d, 8'h8d, 8'h09, 8'h81, 8'h7d, 8'h32,
		8'hbd, 8'h8f, 8'h40, 8'heb, 8'h86, 8'hb7, 8'h7b, 8'h0b, 8'hf0, 8'h95, 8'h21, 8'h22,
		8'h5c, 8'h6b, 8'h4e, 8'h82, 8'h54, 8'hd6, 8'h65, 8'h93, 8'hce, 8'h60, 8'hb2, 8'h1c,
		8'h73, 8'h56, 8'hc0, 8'h14, 8'ha7, 8'h8c, 8'hf1, 8'hdc, 8'h12, 8'h75, 8'hca, 8'h1f,
		8'h3b, 8'hbe, 8'he4, 8'hd1, 8'h42, 8'h3d, 8'hd4, 8'h30, 8'ha3, 8'h3c, 8'hb6, 8'h26,
		8'h6f, 8'hbf, 8'h0e, 8'hda, 8'h46, 8'h69, 8'h07, 8'h57, 8'h27, 8'hf2, 8'h1d, 8'h9b,
		8'hbc, 8'h94, 8'h43, 8'h03, 8'hf8, 8'h11, 8'hc7, 8'hf6, 8'h90, 8'hef, 8'h3e, 8'he7,
		8'h06, 8'hc3, 8'hd5, 8'h2f, 8'hc8, 8'h66, 8'h1e, 8'hd7, 8'h08, 8'he8, 8'hea, 8'hde,
		8'h80, 8'h52, 8'hee, 8'hf7, 8'h84, 8'haa, 8'h72, 8'hac, 8'h35, 8'h4d, 8'h6a, 8'h2a,
		8'h96, 8'h1a, 8'hd2, 8'h71, 8'h5a, 8'h15, 8'h49, 8'h74, 8'h4b, 8'h9f, 8'hd0, 8'h5e,
		8'h04, 8'h18, 8'ha4, 8'hec, 8'hc2, 8'he0, 8'h41, 8'h6e, 8'h0f, 8'h51, 8'hcb, 8'hcc,
		8'h24, 8'h91, 8'haf, 8'h50, 8'ha1, 8'hf4, 8'h70, 8'h39, 8'h99, 8'h7c, 8'h3a, 8'h85,
		8'h23, 8'hb8, 8'hb4, 8'h7a, 8'hfc, 8'h02, 8'h36, 8'h5b, 8'h25, 8'h55, 8'h97, 8'h31,
		8'h2d, 8'h5d, 8'hfa, 8'h98, 8'he3, 8'h8a, 8'h92, 8'hae, 8'h05, 8'hdf, 8'h29, 8'h10,
		8'h67, 8'h6c, 8'hba, 8'hc9, 8'hd3, 8'h00, 8'he6, 8'hcf, 8'he1, 8'h9e, 8'ha8, 8'h2c,
		8'h63, 8'h16, 8'h01, 8'h3f, 8'h58, 8'he2, 8'h89, 8'ha9, 8'h0d, 8'h38, 8'h34, 8'h1b,
		8'hab, 8'h33, 8'hff, 8'hb0, 8'hbb, 8'h48, 8'h0c, 8'h5f, 8'hb9, 8'hb1, 8'hcd, 8'h2e,
		8'hc5, 8'hf3, 8'hdb, 8'h47, 8'he5, 8'ha5, 8'h9c, 8'h77, 8'h0a, 8'ha6, 8'h20, 8'h68,
		8'hfe, 8'h7f, 8'hc1, 8'had
	};

	// rotate left by 1, 2, 3, 5 for words 0..3
	function automatic logic [15:0] rol_enc(input logic [15:0] v, input logic [1:0] w);
		case (w)
			2'd0: return {v[14:0], v[15]};
			2'd1: return {v[13:0], v[15:14]};
			2'd2: return {v[12:0], v[15:13]};
			default: return {v[10:0], v[15:11]};
		endcase
	endfunction

	// inverse rotation
	function automatic logic [15:0] ror_dec(input logic [15:0] v, input logic [1:0] w);
		case (w)
			2'd0: return {v[0], v[15:1]};
			2'd1: return {v[1:0], v[15:2]};
			2'd2: return {v[2:0], v[15:3]};
			default: return {v[4:0], v[15:5]};
		endcase
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/rc2cbc_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module rc2cbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/rc2cbc_ctrl.sv */
// controller: sequences key expansion, cipher rounds and result handoff
`default_nettype none
module rc2cbc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	input  wire rc2cbc_pkg::status_t status,
	output rc2cbc_pkg::cmd_t         cmd
);
	import rc2cbc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_KLOAD = 4'd1;
	localparam logic [3:0] S_KFILL = 4'd2;
	localparam logic [3:0] S_KRED  = 4'd3;
	localparam logic [3:0] S_KBACK = 4'd4;
	localparam logic [3:0] S_KCOPY = 4'd5;
	localparam logic [3:0] S_START = 4'd6;
	localparam logic [3:0] S_MIX   = 4'd7;
	localparam logic [3:0] S_MASH  = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0] state_q;
	logic [6:0] cnt_q;
	logic       ph_q;
	logic [5:0] step_q;
	logic [1:0] mash_q;
	logic       key_ready_q;
	logic       m_tvalid_q;
	logic [6:0] red_idx;

	assign red_idx = 7'(8'd128 - status.t8);

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.in_load = s_tvalid;
			end
			S_KLOAD: begin
				cmd.op = OP_KEY;
				cmd.e_waddr = cnt_q;
			end
			S_KFILL: begin
				cmd.e_raddr = cnt_q - 7'(status.len);
				cmd.e_waddr = cnt_q;
				if (ph_q) begin
					cmd.op = OP_FILL;
				end
			end
			S_KRED: begin
				cmd.e_raddr = red_idx;
				cmd.e_waddr = red_idx;
				if (ph_q) begin
					cmd.op = OP_RED;
				end
			end
			S_KBACK: begin
				cmd.e_raddr = cnt_q + status.t8[6:0];
				cmd.e_waddr = cnt_q;
				if (ph_q) begin
					cmd.op = OP_BACK;
				end
			end
			S_KCOPY: begin
				cmd.e_raddr = cnt_q;
				cmd.k_waddr = cnt_q[6:1];
				if (ph_q) begin
					cmd.op = cnt_q[0] ? OP_SK : OP_LO;
				end
			end
			S_START: begin
				cmd.x_load = 1'b1;
			end
			S_MIX: begin
				cmd.k_raddr = status.dec ? ~step_q : step_q;
				cmd.w = status.dec ? ~step_q[1:0] : step_q[1:0];
				if (ph_q) begin
					cmd.op = OP_MIX;
				end
			end
			S_MASH: begin
				cmd.k_rsel_data = 1'b1;
				cmd.w = status.dec ? ~mash_q : mash_q;
				if (ph_q) begin
					cmd.op = OP_MASH;
				end
			end
			S_FIN: begin
				cmd.out_load = !m_tvalid_q || m_tready;
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ph_q <= 1'b0;
			step_q <= '0;
			mash_q <= '0;
			key_ready_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (status.key_wr) begin
				key_ready_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					ph_q <= 1'b0;
					cnt_q <= '0;
					if (s_tvalid) begin
						state_q <= key_ready_q ? S_START : S_KLOAD;
					end
				end
				S_KLOAD: begin
					if (8'(cnt_q) + 8'd1 == 8'(status.len)) begin
						state_q <= S_KFILL;
						cnt_q <= 7'(status.len);
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_KFILL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cnt_q == 7'd127) begin
							state_q <= S_KRED;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				S_KRED: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (status.t8 == 8'd128) begin
							state_q <= S_KCOPY;
							cnt_q <= '0;
						end else begin
							state_q <= S_KBACK;
							cnt_q <= 7'(8'd127 - status.t8);
						end
					end
				end
				S_KBACK: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cnt_q == 7'd0) begin
							state_q <= S_KCOPY;
						end else begin
							cnt_q <= cnt_q - 7'd1;
						end
					end
				end
				S_KCOPY: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q == 7'd127) begin
							state_q <= S_START;
							key_ready_q <= 1'b1;
						end
					end
				end
				S_START: begin
					state_q <= S_MIX;
					step_q <= '0;
					ph_q <= 1'b0;
				end
				S_MIX: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (step_q[1:0] == 2'd3 && (step_q[5:2] == 4'd4 || step_q[5:2] == 4'd10))
						begin
							state_q <= S_MASH;
							mash_q <= '0;
						end else if (step_q == 6'd63) begin
							state_q <= S_FIN;
						end else begin
							step_q <= step_q + 6'd1;
						end
					end
				end
				S_MASH: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (mash_q == 2'd3) begin
							state_q <= S_MIX;
							step_q <= step_q + 6'd1;
						end else begin
							mash_q <= mash_q + 2'd1;
						end
					end
				end
				S_FIN: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

/* hw/rtl/rc2cbc_dp.sv */
// datapath: config registers, expansion and subkey memories, cipher words, chaining
`default_nettype none
module rc2cbc_dp #(
	parameter int MAX_KEY_BYTES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [63:0]         cfg_data,
	input  wire logic [63:0]         s_tdata,
	input  wire logic                s_tlast,
	output logic      [63:0]         m_tdata,
	input  wire rc2cbc_pkg::cmd_t    cmd,
	output rc2cbc_pkg::status_t      status
);
	import rc2cbc_pkg::*;

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [4:0]  key_len_q;
	logic [10:0] eff_bits_q;
	logic [63:0] iv_q;
	logic [1:0]  mode_q;

	logic [63:0] in_q;
	logic        last_q;
	logic [63:0] chain_q;
	logic        start_q;
	logic [63:0] out_q;
	logic [7:0]  prev_q;
	logic [7:0]  lo_q;
	logic [15:0] y_q [4];

	logic [4:0]  len;
	logic [10:0] bits;
	logic [7:0]  mask;
	logic        dec;
	logic [63:0] key_src;
	logic [7:0]  key_byte;
	logic [7:0]  e_wdata;
	logic [7:0]  e_rdata;
	logic        e_we;
	logic [15:0] k_rdata;
	logic [5:0]  k_raddr;
	logic [15:0] mix_f;
	logic [15:0] new0;
	logic [63:0] blk;
	logic [63:0] result;

	always_comb begin
		if (key_len_q == 5'd0) begin
			len = 5'd1;
		end else if (key_len_q > 5'(MAX_KEY_BYTES)) begin
			len = 5'(MAX_KEY_BYTES);
		end else begin
			len = key_len_q;
		end
		if (eff_bits_q == 11'd0 || eff_bits_q > 11'd1024) begin
			bits = 11'd1024;
		end else begin
			bits = eff_bits_q;
		end
	end

	assign mask = 8'hff >> (3'd0 - bits[2:0]);
	assign dec = (mode_q == MODE_DEC);

	assign status.len = len;
	assign status.t8 = 8'((12'(bits) + 12'd7) >> 3);
	assign status.key_wr = cfg_we && (cfg_index inside {REG_KEY_LOW, REG_KEY_HIGH,
		REG_KEY_LEN, REG_EFF_BITS});
	assign status.dec = dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			key_len_q <= 5'd16;
			eff_bits_q <= 11'd128;
			iv_q <= '0;
			mode_q <= MODE_CBC;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW:  key_low_q <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LEN:  key_len_q <= cfg_data[4:0];
				REG_EFF_BITS: eff_bits_q <= cfg_data[10:0];
				REG_IV:       iv_q <= cfg_data;
				REG_MODE:     mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// key expansion byte path
	assign key_src = cmd.e_waddr[3] ? key_high_q : key_low_q;
	assign key_byte = 8'(key_src >> {cmd.e_waddr[2:0], 3'b000});

	always_comb begin
		case (cmd.op)
			OP_FILL: e_wdata = PITABLE[e_rdata + prev_q];
			OP_RED:  e_wdata = PITABLE[e_rdata & mask];
			OP_BACK: e_wdata = PITABLE[e_rdata ^ prev_q];
			default: e_wdata = key_byte;
		endcase
	end

	assign e_we = cmd.op inside {OP_KEY, OP_FILL, OP_RED, OP_BACK};
	assign k_raddr = cmd.k_rsel_data ? y_q[3][5:0] : cmd.k_raddr;

	rc2cbc_ram #(.WIDTH(8), .DEPTH(128)) u_exp_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(cmd.e_waddr),
		.wdata(e_wdata),
		.raddr(cmd.e_raddr),
		.rdata(e_rdata)
	);

	rc2cbc_ram #(.WIDTH(16), .DEPTH(64)) u_sk_ram (
		.clk  (clk),
		.we   (cmd.op == OP_SK),
		.waddr(cmd.k_waddr),
		.wdata({e_rdata, lo_q}),
		.raddr(k_raddr),
		.rdata(k_rdata)
	);

	// word 0 of the rotated view is always the word being updated
	assign mix_f = (y_q[1] & ~y_q[3]) + (y_q[2] & y_q[3]);

	always_comb begin
		if (cmd.op == OP_MASH) begin
			new0 = dec ? (y_q[0] - k_rdata) : (y_q[0] + k_rdata);
		end else if (dec) begin
			new0 = ror_dec(y_q[0], cmd.w) - mix_f - k_rdata;
		end else begin
			new0 = rol_enc(y_q[0] + mix_f + k_rdata, cmd.w);
		end
	end

	assign blk = in_q ^ ((mode_q == MODE_CBC) ? (start_q ? iv_q : chain_q) : 64'd0);
	assign result = dec ? {y_q[0], y_q[3], y_q[2], y_q[1]}
		: {y_q[3], y_q[2], y_q[1], y_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			start_q <= 1'b1;
		end else if (cmd.out_load && mode_q == MODE_CBC) begin
			chain_q <= result;
			start_q <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_q <= s_tdata;
			last_q <= s_tlast;
		end
		if (e_we) begin
			prev_q <= e_wdata;
		end
		if (cmd.op == OP_LO) begin
			lo_q <= e_rdata;
		end
		if (cmd.out_load) begin
			out_q <= result;
		end
		if (cmd.x_load) begin
			if (dec) begin
				y_q[0] <= blk[63:48];
				y_q[1] <= blk[15:0];
				y_q[2] <= blk[31:16];
				y_q[3] <= blk[47:32];
			end else begin
				y_q[0] <= blk[15:0];
				y_q[1] <= blk[31:16];
				y_q[2] <= blk[47:32];
				y_q[3] <= blk[63:48];
			end
		end else if (cmd.op == OP_MIX || cmd.op == OP_MASH) begin
			if (dec) begin
				y_q[0] <= y_q[3];
				y_q[1] <= new0;
				y_q[2] <= y_q[1];
				y_q[3] <= y_q[2];
			end else begin
				y_q[0] <= y_q[1];
				y_q[1] <= y_q[2];
				y_q[2] <= y_q[3];
				y_q[3] <= new0;
			end
		end
	end

	assign m_tdata = out_q;

endmodule
`default_nettype wire

/* hw/rtl/rc2_block_cipher_cbc.sv */
// top level of the rc2 block cipher with cbc chaining
// One 64-bit block in, one 64-bit block out. With the key already expanded a block
// passes through a load state, 64 word updates and 8 mash word updates, each with an
// address phase and an update phase (for the registered read port of the 64x16 subkey
// memory), and a handoff state into the output register. With a free output the next
// block can be taken in the cycle after the handoff. After any write to key_low,
// key_high, key_length or effective_bits the next block first runs the key expansion
// on a 128x8 memory: it loads the key bytes, runs the fill, reduction and backward
// passes with a read phase and a write phase per byte, and packs the expanded bytes
// into the 64 subkeys. A new block is taken once the previous one has moved to the
// output register; configuration must be written only while the block is idle, which
// the block itself does not enforce.
`default_nettype none
module rc2_block_cipher_cbc #(
	parameter int MAX_KEY_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // data_block
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata   // result_block
);
	import rc2cbc_pkg::*;

	`include "assert_macros.svh"

	cmd_t    cmd;
	status_t status;

	rc2cbc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	rc2cbc_dp #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_IMPLIES(a_out_free_on_load, clk, arst_n, cmd.out_load, !m_tvalid || m_tready)
	`ASSERT_IMPLIES(a_no_load_while_busy, clk, arst_n, cmd.x_load || cmd.op == OP_MIX, !s_tready)

endmodule
`default_nettype wire
